### hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Shared constants, register indexes and the beat structures used between
// the top level and the bus sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int MAX_ADDR_BYTES = 4;
   localparam int COUNT_WIDTH    = 16;
   localparam int ADDR_CNT_W     = 3;
   localparam int ADDR_IDX_W     = (MAX_ADDR_BYTES > 1) ? $clog2(MAX_ADDR_BYTES) : 1;
   localparam int REG_ADDR_W     = 32;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDR    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_POLL_LIMIT = 1'b1;

   localparam logic [7:0] DEVICE_ADDR_RESET    = 8'h00;
   localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd200;
   localparam logic [7:0] READ_BIT             = 8'h01;

   typedef struct packed {
      logic [7:0] device_addr;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic                  action;
      logic                  is_read;
      logic [REG_ADDR_W-1:0] reg_addr;
      logic [2:0]            addr_bytes;
      logic [15:0]           byte_count;
      logic [7:0]            wr_byte;
      logic                  sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_low;
      logic       data_taken;
      logic       rd_valid;
      logic [7:0] rd_byte;
      logic       done_res;
      logic       nack;
      logic       busy_res;
   } rsp_type;

endpackage

### hw/rtl/i2cm_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the transfer state and advances it by one delay unit for each
// accepted tick beat; the result for that beat is presented combinationally.
// ----------------------------------------------------------------------------
module i2cm_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'd0,
      PH_START = 5'd1,
      PH_WBIT  = 5'd2,
      PH_WACK  = 5'd3,
      PH_POLL  = 5'd4,
      PH_WDATA = 5'd5,
      PH_STOP  = 5'd6,
      PH_RREL  = 5'd7,
      PH_RBIT  = 5'd8,
      PH_RACK  = 5'd9
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             sub_ff, sub_in;
   logic [7:0]             shift_ff, shift_in;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [ADDR_CNT_W-1:0]  addr_left_ff, addr_left_in;
   logic [COUNT_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [REG_ADDR_W-1:0]  addr_hold_ff, addr_hold_in;
   logic                   read_flag_ff, read_flag_in;
   logic [7:0]             poll_ff, poll_in;
   logic                   second_ff, second_in;
   logic                   aborted_ff, aborted_in;
   logic                   scl_ff, scl_in;
   logic                   sda_low_ff, sda_low_in;

   logic [3:0]             bit_inc;
   logic [7:0]             poll_inc;
   logic [ADDR_CNT_W-1:0]  addr_dec;
   logic [ADDR_IDX_W-1:0]  addr_idx;
   logic [7:0]             rd_shift;
   logic                   taken, rvalid, done, nk;
   logic [7:0]             rbyte;

   assign bit_inc  = bit_count_ff + 4'd1;
   assign poll_inc = poll_ff + 8'd1;
   assign addr_dec = addr_left_ff - ADDR_CNT_W'(1);
   assign addr_idx = addr_dec[ADDR_IDX_W-1:0];
   assign rd_shift = {shift_ff[6:0], req.sda_in};

   always_comb begin
      phase_in      = phase_ff;
      sub_in        = sub_ff;
      shift_in      = shift_ff;
      bit_count_in  = bit_count_ff;
      addr_left_in  = addr_left_ff;
      bytes_left_in = bytes_left_ff;
      addr_hold_in  = addr_hold_ff;
      read_flag_in  = read_flag_ff;
      poll_in       = poll_ff;
      second_in     = second_ff;
      aborted_in    = aborted_ff;
      scl_in        = scl_ff;
      sda_low_in    = sda_low_ff;
      taken         = 1'b0;
      rvalid        = 1'b0;
      rbyte         = 8'h00;
      done          = 1'b0;
      nk            = 1'b0;

      if (req.action) begin
         // A command is only latched here; the start condition follows on the next tick.
         if (phase_ff == PH_IDLE) begin
            read_flag_in = req.is_read;
            addr_hold_in = req.reg_addr;
            if (req.addr_bytes > ADDR_CNT_W'(MAX_ADDR_BYTES)) begin
               addr_left_in = ADDR_CNT_W'(MAX_ADDR_BYTES);
            end else begin
               addr_left_in = req.addr_bytes;
            end
            if (req.is_read && (req.byte_count[COUNT_WIDTH-1:0] == '0)) begin
               bytes_left_in = COUNT_WIDTH'(1);
            end else begin
               bytes_left_in = req.byte_count[COUNT_WIDTH-1:0];
            end
            second_in    = 1'b0;
            aborted_in   = 1'b0;
            bit_count_in = 4'd0;
            shift_in     = 8'h00;
            poll_in      = 8'h00;
            phase_in     = PH_START;
            sub_in       = 2'd0;
         end
      end else begin
         unique case (phase_ff)
            PH_START: begin
               unique case (sub_ff)
                  2'd0: begin
                     scl_in     = 1'b1;
                     sda_low_in = 1'b0;
                     sub_in     = 2'd1;
                  end
                  2'd1: begin
                     sda_low_in = 1'b1;
                     sub_in     = 2'd2;
                  end
                  default: begin
                     scl_in       = 1'b0;
                     shift_in     = second_ff ? (cfg.device_addr | READ_BIT) : cfg.device_addr;
                     bit_count_in = 4'd0;
                     phase_in     = PH_WBIT;
                     sub_in       = 2'd0;
                  end
               endcase
            end
            PH_WDATA: begin
               shift_in      = req.wr_byte;
               taken         = 1'b1;
               bytes_left_in = bytes_left_ff - COUNT_WIDTH'(1);
               bit_count_in  = 4'd0;
               sda_low_in    = ~req.wr_byte[7];
               phase_in      = PH_WBIT;
               sub_in        = 2'd1;
            end
            PH_WBIT: begin
               unique case (sub_ff)
                  2'd0: begin
                     sda_low_in = ~shift_ff[7];
                     sub_in     = 2'd1;
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     sub_in = 2'd2;
                  end
                  default: begin
                     scl_in       = 1'b0;
                     shift_in     = {shift_ff[6:0], 1'b0};
                     bit_count_in = bit_inc;
                     sub_in       = 2'd0;
                     if (bit_inc >= 4'd8) begin
                        phase_in = PH_WACK;
                     end
                  end
               endcase
            end
            PH_WACK: begin
               if (sub_ff == 2'd0) begin
                  sda_low_in = 1'b0;
                  sub_in     = 2'd1;
               end else begin
                  scl_in   = 1'b1;
                  poll_in  = 8'h00;
                  phase_in = PH_POLL;
                  sub_in   = 2'd0;
               end
            end
            PH_POLL: begin
               if (!req.sda_in) begin
                  scl_in     = 1'b0;
                  sda_low_in = 1'b0;
                  sub_in     = 2'd0;
                  // Acknowledged: next address byte, then read restart, read data, write data or stop.
                  if (addr_left_ff != '0) begin
                     shift_in     = addr_hold_ff[8*addr_idx +: 8];
                     addr_left_in = addr_dec;
                     bit_count_in = 4'd0;
                     phase_in     = PH_WBIT;
                  end else if (read_flag_ff) begin
                     phase_in = second_ff ? PH_RREL : PH_STOP;
                  end else if (bytes_left_ff != '0) begin
                     phase_in = PH_WDATA;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end else begin
                  poll_in = poll_inc;
                  if (poll_inc == cfg.ack_poll_limit) begin
                     scl_in     = 1'b0;
                     aborted_in = 1'b1;
                     phase_in   = PH_STOP;
                     sub_in     = 2'd0;
                  end
               end
            end
            PH_STOP: begin
               unique case (sub_ff)
                  2'd0: begin
                     sda_low_in = 1'b1;
                     sub_in     = 2'd1;
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     sub_in = 2'd2;
                  end
                  2'd2: begin
                     sda_low_in = 1'b0;
                     sub_in     = 2'd3;
                  end
                  2'd3: begin
                     sub_in = 2'd0;
                     if (!aborted_ff && read_flag_ff && !second_ff) begin
                        second_in = 1'b1;
                        phase_in  = PH_START;
                     end else begin
                        done     = 1'b1;
                        nk       = aborted_ff;
                        phase_in = PH_IDLE;
                     end
                  end
               endcase
            end
            PH_RREL: begin
               sda_low_in   = 1'b0;
               bit_count_in = 4'd0;
               shift_in     = 8'h00;
               phase_in     = PH_RBIT;
               sub_in       = 2'd0;
            end
            PH_RBIT: begin
               if (sub_ff == 2'd0) begin
                  if (bit_count_ff != 4'd0) begin
                     shift_in = rd_shift;
                  end
                  scl_in = 1'b0;
                  sub_in = 2'd1;
               end else begin
                  scl_in       = 1'b1;
                  bit_count_in = bit_inc;
                  sub_in       = 2'd0;
                  if (bit_inc >= 4'd8) begin
                     phase_in = PH_RACK;
                  end
               end
            end
            PH_RACK: begin
               unique case (sub_ff)
                  2'd0: begin
                     shift_in      = rd_shift;
                     rvalid        = 1'b1;
                     rbyte         = rd_shift;
                     scl_in        = 1'b0;
                     bytes_left_in = bytes_left_ff - COUNT_WIDTH'(1);
                     sub_in        = 2'd1;
                  end
                  2'd1: begin
                     // Every byte but the last is acknowledged.
                     sda_low_in = (bytes_left_ff != '0);
                     sub_in     = 2'd2;
                  end
                  2'd2: begin
                     scl_in = 1'b1;
                     sub_in = 2'd3;
                  end
                  2'd3: begin
                     scl_in   = 1'b0;
                     sub_in   = 2'd0;
                     phase_in = (bytes_left_ff == '0) ? PH_STOP : PH_RREL;
                  end
               endcase
            end
            PH_IDLE: begin
               scl_in     = 1'b1;
               sda_low_in = 1'b0;
            end
            default: begin
               phase_in = PH_IDLE;
               sub_in   = 2'd0;
            end
         endcase
      end

      rsp.scl        = scl_in;
      rsp.sda_low    = sda_low_in;
      rsp.data_taken = taken;
      rsp.rd_valid   = rvalid;
      rsp.rd_byte    = rbyte;
      rsp.done_res   = done;
      rsp.nack       = nk;
      rsp.busy_res   = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         sub_ff        <= 2'd0;
         shift_ff      <= 8'h00;
         bit_count_ff  <= 4'd0;
         addr_left_ff  <= '0;
         bytes_left_ff <= '0;
         addr_hold_ff  <= '0;
         read_flag_ff  <= 1'b0;
         poll_ff       <= 8'h00;
         second_ff     <= 1'b0;
         aborted_ff    <= 1'b0;
         scl_ff        <= 1'b1;
         sda_low_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         sub_ff        <= sub_in;
         shift_ff      <= shift_in;
         bit_count_ff  <= bit_count_in;
         addr_left_ff  <= addr_left_in;
         bytes_left_ff <= bytes_left_in;
         addr_hold_ff  <= addr_hold_in;
         read_flag_ff  <= read_flag_in;
         poll_ff       <= poll_in;
         second_ff     <= second_in;
         aborted_ff    <= aborted_in;
         scl_ff        <= scl_in;
         sda_low_ff    <= sda_low_in;
      end
   end

endmodule

### hw/rtl/i2c_master_register_transfer_top.sv
// ----------------------------------------------------------------------------
// I2C master register transfer
// Top level: configuration registers, request handshake and result register.
// ----------------------------------------------------------------------------
// Each request beat is either a command or one delay tick of bus timing, and
// every beat yields exactly one result beat carrying the SCL and SDA levels
// to drive for that delay unit plus the data and status flags. The sequencer
// updates its state in a single pass and the result lands in the output
// register on the edge that accepts the request, so one beat can be taken
// every cycle while the result side keeps up. A held result does not block
// the next request when it is taken in the same cycle. The user must write
// registers through the csr port only while no transfer runs; the block does not enforce it.
module i2c_master_register_transfer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic                             req_is_read,
   input  logic [i2cm_pkg::REG_ADDR_W-1:0]  req_reg_addr,
   input  logic [2:0]                       req_addr_bytes,
   input  logic [15:0]                      req_byte_count,
   input  logic [7:0]                       req_wr_byte,
   input  logic                             req_sda_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_scl,
   output logic                             rsp_sda_low,
   output logic                             rsp_data_taken,
   output logic                             rsp_rd_valid,
   output logic [7:0]                       rsp_rd_byte,
   output logic                             rsp_done_res,
   output logic                             rsp_nack,
   output logic                             rsp_busy_res,
   input  logic                             csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import i2cm_pkg::*;

   cfg_type cfg_ff;
   req_type req;
   rsp_type step_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign req.action     = req_action;
   assign req.is_read    = req_is_read;
   assign req.reg_addr   = req_reg_addr;
   assign req.addr_bytes = req_addr_bytes;
   assign req.byte_count = req_byte_count;
   assign req.wr_byte    = req_wr_byte;
   assign req.sda_in     = req_sda_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_addr    <= DEVICE_ADDR_RESET;
         cfg_ff.ack_poll_limit <= ACK_POLL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVICE_ADDR:    cfg_ff.device_addr    <= csr_wdata;
            CSR_ACK_POLL_LIMIT: cfg_ff.ack_poll_limit <= csr_wdata;
            default:            ;
         endcase
      end
   end

   i2cm_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .req     (req),
      .cfg     (cfg_ff),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = rsp_ff.scl;
   assign rsp_sda_low    = rsp_ff.sda_low;
   assign rsp_data_taken = rsp_ff.data_taken;
   assign rsp_rd_valid   = rsp_ff.rd_valid;
   assign rsp_rd_byte    = rsp_ff.rd_byte;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_nack       = rsp_ff.nack;
   assign rsp_busy_res   = rsp_ff.busy_res;

endmodule

### hw/rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master register transfer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl,
   input logic       rsp_sda_low,
   input logic       rsp_data_taken,
   input logic       rsp_rd_valid,
   input logic [7:0] rsp_rd_byte,
   input logic       rsp_done_res,
   input logic       rsp_nack,
   input logic       rsp_busy_res
);

   // A stalled result beat must hold its done flag, read byte and bus levels.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_res) && $stable(rsp_rd_byte)
      && $stable(rsp_scl) && $stable(rsp_sda_low))
      else $error("result beat changed while stalled");

   a_nack_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nack |-> rsp_done_res && !rsp_busy_res)
      else $error("nack without end of transfer");

   // Outside a transfer the bus must be left with SCL high and SDA released.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl && !rsp_sda_low)
      else $error("bus not released while idle");

   a_rd_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rd_valid |-> rsp_rd_byte == 8'h00)
      else $error("read byte not cleared");

   a_taken_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_taken || rsp_rd_valid) |-> rsp_busy_res && !rsp_done_res)
      else $error("data beat outside a transfer");

endmodule

bind i2c_master_register_transfer_top i2cm_checker u_i2cm_checker (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// I2C master register transfer testbench
// Drives command and tick beats into the block, plays the part of a slave
// on the SDA input and predicts every result beat from its own model of the
// bus sequencer. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import i2cm_pkg::*;

   localparam int  CYCLE_LIMIT = 3_000_000;
   localparam int  HOLDOFF_CYCLES = 300;
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_CMD  = 1'b1;
   localparam logic XFER_WRITE = 1'b0;
   localparam logic XFER_READ  = 1'b1;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_START, SEQ_WBIT, SEQ_WACK, SEQ_POLL,
      SEQ_WDATA, SEQ_STOP, SEQ_RREL, SEQ_RBIT, SEQ_RACK
   } seq_phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_action;
   logic                   req_is_read;
   logic [REG_ADDR_W-1:0]  req_reg_addr;
   logic [2:0]             req_addr_bytes;
   logic [15:0]            req_byte_count;
   logic [7:0]             req_wr_byte;
   logic                   req_sda_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_scl;
   logic                   rsp_sda_low;
   logic                   rsp_data_taken;
   logic                   rsp_rd_valid;
   logic [7:0]             rsp_rd_byte;
   logic                   rsp_done_res;
   logic                   rsp_nack;
   logic                   rsp_busy_res;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   i2c_master_register_transfer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_is_read    (req_is_read),
      .req_reg_addr   (req_reg_addr),
      .req_addr_bytes (req_addr_bytes),
      .req_byte_count (req_byte_count),
      .req_wr_byte    (req_wr_byte),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl        (rsp_scl),
      .rsp_sda_low    (rsp_sda_low),
      .rsp_data_taken (rsp_data_taken),
      .rsp_rd_valid   (rsp_rd_valid),
      .rsp_rd_byte    (rsp_rd_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_nack       (rsp_nack),
      .rsp_busy_res   (rsp_busy_res),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Model of the bus sequencer and its registers.
   seq_phase_type   seq_phase = SEQ_IDLE;
   logic [1:0]      seq_sub = '0;
   logic [7:0]      shifter = '0;
   logic [3:0]      bit_n = '0;
   logic [2:0]      addr_left = '0;
   logic [15:0]     data_left = '0;
   logic [31:0]     addr_latch = '0;
   logic            read_xfer = 1'b0;
   logic [7:0]      poll_n = '0;
   logic            second_pass = 1'b0;
   logic            aborted = 1'b0;
   logic            line_scl = 1'b1;
   logic            line_sda_low = 1'b0;
   logic [7:0]      cfg_dev = DEVICE_ADDR_RESET;
   logic [7:0]      cfg_poll = ACK_POLL_LIMIT_RESET;

   rsp_type         expected_lines[$];
   rsp_type         want_rsp;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int busy_cmd_pct = 0;
   int ack_pct = 100;
   int ack_budget = -1;
   int mismatches = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Receiver side: random stalls, plus a long hold-off when a test asks.
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic rsp_type next_bus_lines(input req_type b);
      rsp_type r;
      r = '0;
      if (b.action == ACT_CMD) begin
         if (seq_phase == SEQ_IDLE) begin
            read_xfer = b.is_read;
            addr_latch = b.reg_addr;
            addr_left = (b.addr_bytes > MAX_ADDR_BYTES) ? 3'(MAX_ADDR_BYTES) : b.addr_bytes;
            data_left = (b.is_read && b.byte_count == 16'd0) ? 16'd1 : b.byte_count;
            second_pass = 1'b0;
            aborted = 1'b0;
            bit_n = '0;
            shifter = '0;
            poll_n = '0;
            seq_phase = SEQ_START;
            seq_sub = 2'd0;
         end
      end else begin
         case (seq_phase)
            SEQ_START: begin
               if (seq_sub == 2'd0) begin
                  line_scl = 1'b1;
                  line_sda_low = 1'b0;
                  seq_sub = 2'd1;
               end else if (seq_sub == 2'd1) begin
                  line_sda_low = 1'b1;
                  seq_sub = 2'd2;
               end else begin
                  line_scl = 1'b0;
                  shifter = second_pass ? (cfg_dev | READ_BIT) : cfg_dev;
                  bit_n = '0;
                  seq_phase = SEQ_WBIT;
                  seq_sub = 2'd0;
               end
            end
            SEQ_WDATA: begin
               shifter = b.wr_byte;
               r.data_taken = 1'b1;
               data_left = data_left - 16'd1;
               bit_n = '0;
               line_sda_low = !shifter[7];
               seq_phase = SEQ_WBIT;
               seq_sub = 2'd1;
            end
            SEQ_WBIT: begin
               if (seq_sub == 2'd0) begin
                  line_sda_low = !shifter[7];
                  seq_sub = 2'd1;
               end else if (seq_sub == 2'd1) begin
                  line_scl = 1'b1;
                  seq_sub = 2'd2;
               end else begin
                  line_scl = 1'b0;
                  shifter = shifter << 1;
                  bit_n = bit_n + 4'd1;
                  if (bit_n >= 4'd8) begin
                     seq_phase = SEQ_WACK;
                     seq_sub = 2'd0;
                  end else begin
                     seq_sub = 2'd0;
                  end
               end
            end
            SEQ_WACK: begin
               if (seq_sub == 2'd0) begin
                  line_sda_low = 1'b0;
                  seq_sub = 2'd1;
               end else begin
                  line_scl = 1'b1;
                  poll_n = '0;
                  seq_phase = SEQ_POLL;
                  seq_sub = 2'd0;
               end
            end
            SEQ_POLL: begin
               if (!b.sda_in) begin
                  line_scl = 1'b0;
                  line_sda_low = 1'b0;
                  seq_sub = 2'd0;
                  // An acknowledged byte leads to the next address byte, the
                  // turnaround of a read, the data bytes or the stop.
                  if (addr_left != 3'd0 && addr_left <= MAX_ADDR_BYTES) begin
                     shifter = 8'(addr_latch >> (8 * (addr_left - 3'd1)));
                     addr_left = addr_left - 3'd1;
                     bit_n = '0;
                     seq_phase = SEQ_WBIT;
                  end else if (read_xfer) begin
                     if (second_pass)
                        seq_phase = SEQ_RREL;
                     else
                        seq_phase = SEQ_STOP;
                  end else if (data_left != 16'd0) begin
                     seq_phase = SEQ_WDATA;
                  end else begin
                     seq_phase = SEQ_STOP;
                  end
               end else begin
                  poll_n = poll_n + 8'd1;
                  if (poll_n == cfg_poll) begin
                     line_scl = 1'b0;
                     aborted = 1'b1;
                     seq_phase = SEQ_STOP;
                     seq_sub = 2'd0;
                  end
               end
            end
            SEQ_STOP: begin
               if (seq_sub == 2'd0) begin
                  line_sda_low = 1'b1;
                  seq_sub = 2'd1;
               end else if (seq_sub == 2'd1) begin
                  line_scl = 1'b1;
                  seq_sub = 2'd2;
               end else if (seq_sub == 2'd2) begin
                  line_sda_low = 1'b0;
                  seq_sub = 2'd3;
               end else if (!aborted && read_xfer && !second_pass) begin
                  second_pass = 1'b1;
                  seq_phase = SEQ_START;
                  seq_sub = 2'd0;
               end else begin
                  r.done_res = 1'b1;
                  r.nack = aborted;
                  seq_phase = SEQ_IDLE;
                  seq_sub = 2'd0;
               end
            end
            SEQ_RREL: begin
               line_sda_low = 1'b0;
               bit_n = '0;
               shifter = '0;
               seq_phase = SEQ_RBIT;
               seq_sub = 2'd0;
            end
            SEQ_RBIT: begin
               if (seq_sub == 2'd0) begin
                  if (bit_n > 4'd0)
                     shifter = {shifter[6:0], b.sda_in};
                  line_scl = 1'b0;
                  seq_sub = 2'd1;
               end else begin
                  line_scl = 1'b1;
                  bit_n = bit_n + 4'd1;
                  if (bit_n >= 4'd8) begin
                     seq_phase = SEQ_RACK;
                     seq_sub = 2'd0;
                  end else begin
                     seq_sub = 2'd0;
                  end
               end
            end
            SEQ_RACK: begin
               if (seq_sub == 2'd0) begin
                  shifter = {shifter[6:0], b.sda_in};
                  r.rd_valid = 1'b1;
                  r.rd_byte = shifter;
                  line_scl = 1'b0;
                  data_left = data_left - 16'd1;
                  seq_sub = 2'd1;
               end else if (seq_sub == 2'd1) begin
                  line_sda_low = (data_left != 16'd0);
                  seq_sub = 2'd2;
               end else if (seq_sub == 2'd2) begin
                  line_scl = 1'b1;
                  seq_sub = 2'd3;
               end else begin
                  line_scl = 1'b0;
                  seq_sub = 2'd0;
                  if (data_left == 16'd0)
                     seq_phase = SEQ_STOP;
                  else
                     seq_phase = SEQ_RREL;
               end
            end
            SEQ_IDLE: begin
               line_scl = 1'b1;
               line_sda_low = 1'b0;
            end
            default: begin
               seq_phase = SEQ_IDLE;
               seq_sub = 2'd0;
            end
         endcase
      end
      r.scl = line_scl;
      r.sda_low = line_sda_low;
      r.busy_res = (seq_phase != SEQ_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches = mismatches + 1;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            mismatches = mismatches + 1;
            $display("%0t: result beat with nothing expected, got scl %0b sda_low %0b",
                     $time, rsp_scl, rsp_sda_low);
         end else begin
            want_rsp = expected_lines.pop_front();
            check_field("scl", want_rsp.scl, rsp_scl);
            check_field("sda_low", want_rsp.sda_low, rsp_sda_low);
            check_field("data_taken", want_rsp.data_taken, rsp_data_taken);
            check_field("rd_valid", want_rsp.rd_valid, rsp_rd_valid);
            check_field("rd_byte", want_rsp.rd_byte, rsp_rd_byte);
            check_field("done_res", want_rsp.done_res, rsp_done_res);
            check_field("nack", want_rsp.nack, rsp_nack);
            check_field("busy_res", want_rsp.busy_res, rsp_busy_res);
         end
      end
   end

   // The slave: ACKs a polled byte at ack_pct percent while it still has budget,
   // otherwise it leaves SDA high; read data and all other fields are random.
   function automatic req_type slave_tick();
      req_type t;
      t.action = ACT_TICK;
      t.is_read = 1'($urandom_range(1));
      t.reg_addr = $urandom;
      t.addr_bytes = 3'($urandom_range(7));
      t.byte_count = 16'($urandom_range(16'hFFFF));
      t.wr_byte = 8'($urandom_range(8'hFF));
      if (seq_phase == SEQ_POLL)
         t.sda_in = !(ack_budget != 0 && $urandom_range(99) < ack_pct);
      else
         t.sda_in = 1'($urandom_range(1));
      return t;
   endfunction

   task automatic send_beat(input req_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= b.action;
      req_is_read <= b.is_read;
      req_reg_addr <= b.reg_addr;
      req_addr_bytes <= b.addr_bytes;
      req_byte_count <= b.byte_count;
      req_wr_byte <= b.wr_byte;
      req_sda_in <= b.sda_in;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (b.action == ACT_TICK && seq_phase == SEQ_POLL && !b.sda_in && ack_budget > 0)
         ack_budget = ack_budget - 1;
      expected_lines.push_back(next_bus_lines(b));
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) send_beat(slave_tick());
   endtask

   // One command beat followed by ticks, some turned into commands at busy_cmd_pct, until the transfer has finished.
   task automatic run_transfer(input logic rd, input logic [31:0] reg_addr,
                               input logic [2:0] nab, input logic [15:0] cnt,
                               input int budget);
      req_type c;
      c = slave_tick();
      c.action = ACT_CMD;
      c.is_read = rd;
      c.reg_addr = reg_addr;
      c.addr_bytes = nab;
      c.byte_count = cnt;
      ack_budget = budget;
      send_beat(c);
      while (seq_phase != SEQ_IDLE) begin
         c = slave_tick();
         if ($urandom_range(99) < busy_cmd_pct)
            c.action = ACT_CMD;
         send_beat(c);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lines.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_DEVICE_ADDR)
         cfg_dev = val;
      else
         cfg_poll = val;
   endtask

   task automatic configure(input logic [7:0] dev, input logic [7:0] limit);
      drain();
      write_csr(CSR_DEVICE_ADDR, dev);
      write_csr(CSR_ACK_POLL_LIMIT, limit);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic test_idle_lines();
      set_idling(0, 0);
      // Bit 0 of the device address is set, so the write address goes out as is.
      configure(8'hA1, 8'd200);
      idle_ticks(4);
   endtask

   task automatic test_write_transfer();
      run_transfer(XFER_WRITE, 32'h1234_5678, 3'd1, 16'd1, -1);
   endtask

   task automatic test_read_transfer();
      set_idling(72, 0);
      run_transfer(XFER_READ, $urandom, 3'd0, 16'd2, -1);
   endtask

   task automatic test_address_saturation();
      set_idling(0, 72);
      // Only the device byte is acknowledged: the first address byte shows the
      // saturated count, then the transfer aborts.
      configure(8'h5A, 8'd2);
      run_transfer(XFER_WRITE, 32'hDEAD_BEEF, 3'd7, 16'd0, 1);
   endtask

   task automatic test_missing_ack();
      configure(8'h42, 8'd1);
      run_transfer(XFER_READ, $urandom, 3'd0, 16'd1, 0);
   endtask

   task automatic test_busy_commands();
      set_idling(29, 29);
      configure(8'h3C, 8'd200);
      busy_cmd_pct = 25;
      ack_pct = 70;
      run_transfer(XFER_WRITE, $urandom, 3'd0, 16'd0, -1);
      ack_pct = 100;
      busy_cmd_pct = 0;
   endtask

   task automatic test_receiver_holdoff();
      hold_req = hold_req + 1;
      run_transfer(XFER_READ, $urandom, 3'd0, 16'd0, -1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_TICK;
      req_is_read = 1'b0;
      req_reg_addr = '0;
      req_addr_bytes = '0;
      req_byte_count = '0;
      req_wr_byte = '0;
      req_sda_in = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_lines();
      test_write_transfer();
      test_read_transfer();
      test_address_saturation();
      test_missing_ack();
      test_busy_commands();
      test_receiver_holdoff();

      drain();
      if (mismatches == 0 && expected_lines.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
